FILE: rtl/core/sitda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, constants and helpers for the integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [3:0] CHAR_DIGIT_HI  = 4'h3;   // '0'..'9' are 0x30..0x39

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // take a new value, clear BCD
    logic conv_step;   // one shift-add-3 step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top digit into the output register
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic conv_last;   // this conversion step is the final one
    logic top_zero;    // top BCD digit is zero
    logic one_left;    // one digit remains to send
    logic negative;    // current value is negative
    logic slot_free;   // output register can take a character this cycle
  } dp_stat_t;

  // Add 3 to every BCD digit of 5 or more, ahead of the left shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    logic [3:0]       d;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      res[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sitda_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_num_if / sitda_char_if
// Valid/ready channels: integers in, characters out.
// ----------------------------------------------------------------------------
interface sitda_num_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/signed_int_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints a signed 32-bit integer as decimal ASCII text, one character per item.
// ----------------------------------------------------------------------------
// Channels:
//   number : valid/ready sink, one signed 32-bit value per item.
//   text   : valid/ready source, one ASCII character per item; last_char
//            marks the final character of each number. A negative number
//            starts with '-'; leading zeros are dropped; zero prints "0".
// Sequence:
//   One number at a time. After the accept, one shift-add-3 step per
//   input bit (double dabble) on a 10-digit BCD register, then leading
//   zero digits are dropped one by one (up to 9) before a decision step,
//   then the characters are sent one by one. With an always-ready
//   receiver the next number is accepted as the final character is taken.
// Reset:
//   rst (synchronous, active high) returns the sequencer to idle and
//   empties the output register; any number in progress is dropped.
// Stall:
//   The character sits in an output register until taken; the sequencer
//   waits without loss. The next number is accepted from the cycle after
//   the final character is loaded, even while that character still waits.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  sitda_num_if.sink   number,
  sitda_char_if.source text
);

  ctl_cmd_t cmd;     // sequencer commands to the datapath
  dp_stat_t stat;    // datapath status back to the sequencer

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (number.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: magnitude, BCD register, counters, output character
  sitda_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (number.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.char_code),
    .out_last  (text.last_char)
  );

endmodule
`default_nettype wire

FILE: rtl/core/sitda_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: convert, strip leading zeros, send sign and digits.
// ----------------------------------------------------------------------------
module sitda_ctrl
  import sitda_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.one_left) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = stat.negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (stat.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.one_left) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.conv_step, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
    else $error("more than one datapath command at once");

  a_sign_neg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |-> stat.negative)
    else $error("sign state for a non-negative value");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> stat.slot_free)
    else $error("character loaded over an untaken one");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && stat.one_left) |=> (state == ST_IDLE))
    else $error("no return to idle after final digit");

endmodule
`default_nettype wire

FILE: rtl/core/sitda_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_dp
// Magnitude/BCD registers, step counters and the output character register.
// ----------------------------------------------------------------------------
module sitda_dp
  import sitda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] value,
  input  wire ctl_cmd_t           cmd,
  output dp_stat_t                stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_char,
  output logic                    out_last
);

  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DIG_CNT_W-1:0] digits_left;
  logic                 negative;
  logic [3:0]           top_digit;
  logic                 load_char;

  assign top_digit = bcd[BCD_W-1 -: 4];
  assign load_char = cmd.emit_sign || cmd.emit_digit;
  assign bcd_adj   = bcd_adjust(bcd);

  assign stat.conv_last = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));
  assign stat.top_zero  = (top_digit == 4'd0);
  assign stat.one_left  = (digits_left == DIG_CNT_W'(1));
  assign stat.negative  = negative;
  assign stat.slot_free = !out_valid || out_ready;

  // Conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative    <= value[31];
      mag         <= value[31] ? VALUE_W'(-value) : VALUE_W'(value);
      bcd         <= '0;
      bit_cnt     <= '0;
      digits_left <= DIG_CNT_W'(NUM_DIGITS);
    end else if (cmd.conv_step) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd         <= {bcd[BCD_W-5:0], 4'd0};
      digits_left <= digits_left - DIG_CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= {CHAR_DIGIT_HI, top_digit};
      out_last <= stat.one_left;
    end
  end

endmodule
`default_nettype wire
